// ===== rtl/core/faa_pkg.sv =====
package faa_pkg;

   localparam int MAX_PIXELS  = 1048576;
   localparam int ADDR_W      = $clog2(MAX_PIXELS);
   localparam int FSIZE_W     = ADDR_W + 1;
   localparam int PIX_W       = 20;
   localparam int CNT_W       = 20;
   localparam int DATA_W      = 16;
   localparam int SUM_W       = 36;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 21;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CNT_W-1:0]   COUNT_MAX  = '1;
   localparam logic [FSIZE_W-1:0] FSIZE_MAX  = FSIZE_W'(MAX_PIXELS);

   localparam logic [CSR_ADDR_W-1:0] CSR_PIXELS_PER_FRAME  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PACKED_TWELVE_BIT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_FRAME       = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LAST_FRAME        = 2'd3;

   localparam logic [1:0] ACT_DATA    = 2'd0;
   localparam logic [1:0] ACT_READ    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   typedef enum logic [1:0] {
      CMD_STORE     = 2'd0,
      CMD_ADD       = 2'd1,
      CMD_READ      = 2'd2,
      CMD_READ_ZERO = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] value;
      logic [CNT_W-1:0]  frames;
   } cmd_type;

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_ADD  = 5'b00010,
      B_LOAD = 5'b00100,
      B_DIV  = 5'b01000,
      B_DONE = 5'b10000
   } back_state_type;

endpackage

// ===== rtl/core/faa_ram.sv =====
module faa_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1048576
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/core/faa_queue.sv =====
module faa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  faa_pkg::cmd_type push_cmd,
   input  logic             pop,
   output faa_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);
   import faa_pkg::*;

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = q_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = wr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_in = rd_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/faa_front.sv =====
module faa_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [faa_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [faa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [39:0]                       req_tdata,
   input  logic [1:0]                        req_tuser,
   input  logic                              q_full,
   output logic                              push,
   output faa_pkg::cmd_type                  push_cmd
);
   import faa_pkg::*;

   // configuration
   logic [FSIZE_W-1:0] ppf_ff;
   logic               packed_ff;
   logic [CNT_W-1:0]   first_ff;
   logic [CNT_W-1:0]   last_ff;

   // frame tracking
   logic [CNT_W-1:0]  frame_ff, frame_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [1:0]        phase_ff, phase_in;
   logic [7:0]        held_ff, held_in;
   logic [CNT_W-1:0]  done_ff, done_in;

   logic [FSIZE_W-1:0] fsize;
   logic [CNT_W-1:0]   first_eff;
   logic [CNT_W:0]     idx;
   logic               keep;
   logic [FSIZE_W-1:0] pos_next;
   logic               frame_end;
   logic               accept;
   logic               take;
   logic [DATA_W-1:0]  pix_val;
   logic [DATA_W-1:0]  raw;
   logic [PIX_W-1:0]   pix;

   assign raw = req_tdata[15:0];
   assign pix = req_tdata[35:16];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   always_comb begin
      if (ppf_ff == '0) begin
         fsize = FSIZE_W'(1);
      end else if (ppf_ff > FSIZE_MAX) begin
         fsize = FSIZE_MAX;
      end else begin
         fsize = ppf_ff;
      end
   end

   assign first_eff = (first_ff == '0) ? CNT_W'(1) : first_ff;
   assign idx       = {1'b0, frame_ff} + (CNT_W+1)'(1);
   assign keep      = (idx >= {1'b0, first_eff})
                      && ((last_ff == '0) || (idx <= {1'b0, last_ff}))
                      && (done_ff != COUNT_MAX);
   assign pos_next  = {1'b0, pos_ff} + FSIZE_W'(1);
   assign frame_end = (pos_next >= fsize);

   always_comb begin
      frame_in = frame_ff;
      pos_in   = pos_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      done_in  = done_ff;
      push     = 1'b0;
      push_cmd = '{kind: CMD_STORE, addr: pos_ff, value: '0, frames: done_ff};
      take     = 1'b0;
      pix_val  = raw;
      if (accept) begin
         case (req_tuser)
            ACT_DATA: begin
               if (!packed_ff) begin
                  take = 1'b1;
               end else begin
                  case (phase_ff)
                     2'd0: begin
                        held_in  = raw[7:0];
                        phase_in = 2'd1;
                     end
                     2'd1: begin
                        pix_val  = {4'b0, held_ff, raw[7:4]};
                        held_in  = raw[7:0];
                        phase_in = 2'd2;
                        take     = 1'b1;
                     end
                     default: begin
                        pix_val  = {4'b0, held_ff[3:0], raw[7:0]};
                        phase_in = 2'd0;
                        take     = 1'b1;
                     end
                  endcase
               end
            end
            ACT_READ: begin
               push          = 1'b1;
               push_cmd.addr = pix;
               if ((done_ff == '0) || ({1'b0, pix} >= fsize)) begin
                  push_cmd.kind = CMD_READ_ZERO;
               end else begin
                  push_cmd.kind = CMD_READ;
               end
            end
            ACT_RESTART: begin
               frame_in = '0;
               pos_in   = '0;
               phase_in = '0;
               held_in  = '0;
               done_in  = '0;
            end
            default: begin
            end
         endcase
         if (take) begin
            if (keep) begin
               push           = 1'b1;
               push_cmd.kind  = (done_ff == '0) ? CMD_STORE : CMD_ADD;
               push_cmd.value = pix_val;
            end
            if (frame_end) begin
               pos_in   = '0;
               phase_in = '0;
               if (keep) begin
                  done_in = done_ff + CNT_W'(1);
               end
               if (frame_ff != COUNT_MAX) begin
                  frame_in = frame_ff + CNT_W'(1);
               end
            end else begin
               pos_in = pos_next[ADDR_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppf_ff    <= FSIZE_MAX;
         packed_ff <= 1'b0;
         first_ff  <= CNT_W'(1);
         last_ff   <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PIXELS_PER_FRAME:  ppf_ff    <= csr_wdata[FSIZE_W-1:0];
            CSR_PACKED_TWELVE_BIT: packed_ff <= csr_wdata[0];
            CSR_FIRST_FRAME:       first_ff  <= csr_wdata[CNT_W-1:0];
            CSR_LAST_FRAME:        last_ff   <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         pos_ff   <= '0;
         phase_ff <= '0;
         held_ff  <= '0;
         done_ff  <= '0;
      end else begin
         frame_ff <= frame_in;
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         done_ff  <= done_in;
      end
   end

endmodule

// ===== rtl/core/faa_back.sv =====
module faa_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  faa_pkg::cmd_type              head,
   output logic                          pop,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [55:0]                   rsp_tdata,
   output logic                          rsp_tuser
);
   import faa_pkg::*;

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]  frames_ff, frames_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [3:0]        cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic [PIX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [CNT_W-1:0]  rsp_frames_ff, rsp_frames_in;
   logic              rsp_none_ff, rsp_none_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [SUM_W-1:0]  ram_wdata;
   logic [SUM_W-1:0]  ram_rdata;

   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;

   faa_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_PIXELS)
   ) u_sums (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (head.addr),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_frames_ff, rsp_idx_ff, rsp_avg_ff};
   assign rsp_tuser  = rsp_none_ff;

   // one restoring division step per cycle
   assign trial = {rem_ff, quo_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, frames_ff};

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      value_in      = value_ff;
      frames_in     = frames_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_frames_in = rsp_frames_ff;
      rsp_none_in   = rsp_none_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = head.addr;
      ram_wdata     = SUM_W'(head.value);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop       = 1'b1;
               addr_in   = head.addr;
               value_in  = head.value;
               frames_in = head.frames;
               case (head.kind)
                  CMD_STORE: begin
                     ram_we = 1'b1;
                  end
                  CMD_ADD: begin
                     state_in = B_ADD;
                  end
                  CMD_READ: begin
                     state_in = B_LOAD;
                  end
                  CMD_READ_ZERO: begin
                     quo_in   = '0;
                     state_in = B_DONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         B_ADD: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = ram_rdata + SUM_W'(value_ff);
            state_in  = B_IDLE;
         end
         B_LOAD: begin
            // quotient of 2^16 or more saturates
            if (ram_rdata[SUM_W-1:DATA_W] >= frames_ff) begin
               quo_in   = '1;
               state_in = B_DONE;
            end else begin
               rem_in   = ram_rdata[SUM_W-1:DATA_W];
               quo_in   = ram_rdata[DATA_W-1:0];
               cnt_in   = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (trial >= {1'b0, frames_ff}) begin
               rem_in = diff[CNT_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = trial[CNT_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_avg_in    = quo_ff;
               rsp_idx_in    = addr_ff;
               rsp_frames_in = frames_ff;
               rsp_none_in   = (frames_ff == '0);
               state_in      = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      value_ff      <= value_in;
      frames_ff     <= frames_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_none_ff   <= rsp_none_in;
   end

endmodule

// ===== rtl/core/frame_average_accumulator_core.sv =====
// a word is taken in every cycle while the 4-entry command queue has room
// sum engine: a first-frame store writes straight from the queue head; an add reads the sum, then writes it in B_ADD
// readout: zero results go straight to B_DONE, saturated ones via B_LOAD, others through the 16-step divider
// the back end pops no new command until its state machine is back in B_IDLE
// synchronous reset clears config to defaults, counters, queue and the result valid flag
// the per-pixel sum memory is not cleared; the first kept frame rewrites it
module frame_average_accumulator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [39:0]                    req_tdata,   // raw_data, pixel_index
   input  logic [1:0]                     req_tuser,   // action
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [55:0]                    rsp_tdata,   // average_value, index_echo,
                                                       // frames_averaged
   output logic                           rsp_tuser,   // no_frames
   input  logic                           csr_we,
   input  logic [faa_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [faa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import faa_pkg::*;

   logic    q_full;
   logic    q_empty;
   logic    push;
   logic    pop;
   cmd_type push_cmd;
   cmd_type head;

   faa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   faa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   faa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
